// ===== src/lps_pkg.sv =====
`default_nettype none

package lps_pkg;

  // Operation codes held in the pattern ROM
  typedef enum logic [1:0] {
    OPC_END  = 2'd0,
    OPC_OFF  = 2'd1,
    OPC_ON   = 2'd2,
    OPC_LOOP = 2'd3
  } op_code_t;

  // Which LED an operation drives
  typedef enum logic [1:0] {
    LAMP_GREEN = 2'd0,
    LAMP_RED   = 2'd1,
    LAMP_NONE  = 2'd2
  } lamp_t;

  typedef struct packed {
    logic [7:0] dur;
    lamp_t      lamp;
    op_code_t   code;
  } rom_op_t;

  // ROM geometry
  localparam int ROM_ROWS = 13;
  localparam int ROM_COLS = 16;

  // Durations in 16 ms units
  localparam logic [7:0] D_ZERO      = 8'd0;
  localparam logic [7:0] D_SHORT_ON  = 8'd1;   // 25 ms
  localparam logic [7:0] D_SHORT_OFF = 8'd15;  // 250 ms
  localparam logic [7:0] D_DFU       = 8'd31;  // 500 ms
  localparam logic [7:0] D_LONG      = 8'd62;  // 1000 ms

  localparam rom_op_t END_OP = '{dur: D_ZERO, lamp: LAMP_NONE, code: OPC_END};

  function automatic rom_op_t make_op(input logic [7:0] dur, input lamp_t lamp,
                                      input op_code_t code);
    rom_op_t op;
    op.dur  = dur;
    op.lamp = lamp;
    op.code = code;
    return op;
  endfunction

  // Pattern ROM: unused slots read as END with zero duration
  function automatic rom_op_t rom_read(input logic [3:0] row, input logic [3:0] col);
    rom_op_t op;
    op = END_OP;
    case (row)
      4'd0: begin
        case (col)
          4'd0:    op = make_op(D_ZERO, LAMP_GREEN, OPC_OFF);
          4'd1:    op = make_op(D_ZERO, LAMP_RED, OPC_OFF);
          default: op = END_OP;
        endcase
      end
      4'd1, 4'd3: begin
        case (col)
          4'd0:    op = make_op(D_SHORT_ON, LAMP_GREEN, OPC_ON);
          4'd1:    op = make_op(D_ZERO, LAMP_GREEN, OPC_OFF);
          default: op = END_OP;
        endcase
      end
      4'd2: begin
        case (col)
          4'd0:    op = make_op(D_SHORT_ON, LAMP_RED, OPC_ON);
          4'd1:    op = make_op(D_ZERO, LAMP_RED, OPC_OFF);
          default: op = END_OP;
        endcase
      end
      4'd4: begin
        case (col)
          4'd0:    op = make_op(D_ZERO, LAMP_GREEN, OPC_ON);
          4'd1:    op = make_op(D_SHORT_ON, LAMP_RED, OPC_ON);
          4'd2:    op = make_op(D_ZERO, LAMP_GREEN, OPC_OFF);
          4'd3:    op = make_op(D_LONG, LAMP_RED, OPC_OFF);
          4'd4:    op = make_op(D_ZERO, LAMP_NONE, OPC_LOOP);
          default: op = END_OP;
        endcase
      end
      4'd5: begin
        case (col)
          4'd0, 4'd2, 4'd4: op = make_op(D_LONG, LAMP_GREEN, OPC_ON);
          4'd1, 4'd3:       op = make_op(D_LONG, LAMP_GREEN, OPC_OFF);
          4'd5:             op = make_op(D_ZERO, LAMP_GREEN, OPC_OFF);
          default:          op = END_OP;
        endcase
      end
      4'd6: begin
        case (col)
          4'd0, 4'd2: op = make_op(D_SHORT_ON, LAMP_GREEN, OPC_ON);
          4'd1:       op = make_op(D_SHORT_ON, LAMP_GREEN, OPC_OFF);
          4'd3:       op = make_op(D_ZERO, LAMP_GREEN, OPC_OFF);
          default:    op = END_OP;
        endcase
      end
      4'd7: begin
        case (col)
          4'd0:    op = make_op(D_ZERO, LAMP_GREEN, OPC_ON);
          4'd1:    op = make_op(D_LONG, LAMP_RED, OPC_ON);
          4'd2:    op = make_op(D_ZERO, LAMP_GREEN, OPC_OFF);
          4'd3:    op = make_op(D_ZERO, LAMP_RED, OPC_OFF);
          default: op = END_OP;
        endcase
      end
      4'd8: begin
        case (col)
          4'd0:    op = make_op(D_LONG, LAMP_GREEN, OPC_ON);
          4'd1:    op = make_op(D_ZERO, LAMP_GREEN, OPC_OFF);
          default: op = END_OP;
        endcase
      end
      4'd9: begin
        case (col)
          4'd0, 4'd2, 4'd4: op = make_op(D_SHORT_ON, LAMP_RED, OPC_ON);
          4'd1, 4'd3:       op = make_op(D_SHORT_OFF, LAMP_RED, OPC_OFF);
          4'd5:             op = make_op(D_ZERO, LAMP_RED, OPC_OFF);
          default:          op = END_OP;
        endcase
      end
      4'd10: begin
        case (col)
          4'd0:    op = make_op(D_SHORT_ON, LAMP_GREEN, OPC_ON);
          4'd1:    op = make_op(D_DFU, LAMP_GREEN, OPC_OFF);
          4'd2:    op = make_op(D_SHORT_ON, LAMP_RED, OPC_ON);
          4'd3:    op = make_op(D_DFU, LAMP_RED, OPC_OFF);
          4'd4:    op = make_op(D_ZERO, LAMP_NONE, OPC_LOOP);
          default: op = END_OP;
        endcase
      end
      4'd11: begin
        case (col)
          4'd0:    op = make_op(D_LONG, LAMP_RED, OPC_ON);
          4'd1:    op = make_op(D_ZERO, LAMP_GREEN, OPC_OFF);
          4'd2:    op = make_op(D_ZERO, LAMP_RED, OPC_OFF);
          default: op = END_OP;
        endcase
      end
      4'd12: begin
        case (col)
          4'd0, 4'd2, 4'd4: op = make_op(D_SHORT_ON, LAMP_GREEN, OPC_ON);
          4'd1, 4'd3:       op = make_op(D_SHORT_OFF, LAMP_GREEN, OPC_OFF);
          4'd5:             op = make_op(D_ZERO, LAMP_GREEN, OPC_OFF);
          default:          op = END_OP;
        endcase
      end
      default: op = END_OP;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// ===== src/led_pattern_sequencer_top.sv =====
// An accepted tick that does not expire the timer goes straight to the result state; a
// trigger or an expiring tick first walks ROM operations, up to STEPS_PER_PATTERN of
// them (a trigger for a pattern outside the ROM does not walk), then the result is loaded.
// Throughput: one item at a time; in_stall is high from acceptance until the result is loaded.
// The walk reads one ROM operation per cycle through a single decode and step unit.
// Reset (rst_n low, synchronous) clears the LED state, pattern, step, timer and output valid.
`default_nettype none

module led_pattern_sequencer_top #(
  parameter int STEPS_PER_PATTERN = 16,
  parameter int PATTERN_COUNT     = 13
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // item input
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_opcode,
  input  wire logic [3:0] in_pattern_number,
  // result output
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_green_lit,
  output logic            out_red_lit,
  output logic            out_sequence_running,
  output logic [3:0]      out_current_pattern
);

  localparam int ITER_W  = (STEPS_PER_PATTERN > 2) ? $clog2(STEPS_PER_PATTERN) : 1;
  localparam int PAT_MIN = (PATTERN_COUNT < lps_pkg::ROM_ROWS) ? PATTERN_COUNT
                                                               : lps_pkg::ROM_ROWS;
  localparam logic [4:0]        PAT_LIMIT  = 5'(PAT_MIN);
  localparam logic [5:0]        STEP_LIMIT = 6'(STEPS_PER_PATTERN);
  localparam logic [ITER_W-1:0] ITER_LAST  = ITER_W'(STEPS_PER_PATTERN - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [3:0]        pattern_r, pattern_nxt;
  logic [4:0]        step_index_r, step_index_nxt;
  logic [7:0]        ticks_left_r, ticks_left_nxt;
  logic              timer_armed_r, timer_armed_nxt;
  logic              running_r, running_nxt;
  logic              green_r, green_nxt;
  logic              red_r, red_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_green_r, out_green_nxt;
  logic              out_red_r, out_red_nxt;
  logic              out_running_r, out_running_nxt;
  logic [3:0]        out_pattern_r, out_pattern_nxt;

  lps_pkg::rom_op_t  op;
  logic [4:0]        step_plus;
  logic [7:0]        ticks_dec;
  logic              walk_finish;
  logic              lamp_on;

  function automatic logic pat_ok(input logic [3:0] p);
    return ({1'b0, p} < PAT_LIMIT);
  endfunction

  // Shared walk unit: one ROM read and step increment per cycle
  assign op        = step_index_r[4] ? lps_pkg::END_OP
                                     : lps_pkg::rom_read(pattern_r, step_index_r[3:0]);
  assign step_plus = step_index_r + 5'd1;
  assign ticks_dec = (ticks_left_r != 8'd0) ? (ticks_left_r - 8'd1) : 8'd0;
  assign lamp_on   = (op.code == lps_pkg::OPC_ON);

  // Sequencer next state
  always_comb begin
    state_nxt       = state_r;
    pattern_nxt     = pattern_r;
    step_index_nxt  = step_index_r;
    ticks_left_nxt  = ticks_left_r;
    timer_armed_nxt = timer_armed_r;
    running_nxt     = running_r;
    green_nxt       = green_r;
    red_nxt         = red_r;
    iter_nxt        = iter_r;
    out_valid_nxt   = out_valid_r & out_stall;
    out_green_nxt   = out_green_r;
    out_red_nxt     = out_red_r;
    out_running_nxt = out_running_r;
    out_pattern_nxt = out_pattern_r;
    walk_finish     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          iter_nxt  = '0;
          state_nxt = ST_DONE;
          if (in_opcode) begin
            // trigger: restart pattern from step zero
            timer_armed_nxt = 1'b0;
            ticks_left_nxt  = 8'd0;
            pattern_nxt     = in_pattern_number;
            green_nxt       = 1'b0;
            red_nxt         = 1'b0;
            step_index_nxt  = 5'd0;
            running_nxt     = 1'b1;
            if (pat_ok(in_pattern_number)) begin
              state_nxt = ST_WALK;
            end
          end else if (timer_armed_r) begin
            // tick: count down, continue walk on expiry
            ticks_left_nxt = ticks_dec;
            if (ticks_dec == 8'd0) begin
              timer_armed_nxt = 1'b0;
              if (pat_ok(pattern_r) && ({1'b0, step_index_r} < STEP_LIMIT)) begin
                state_nxt = ST_WALK;
              end
            end
          end
        end
      end

      ST_WALK: begin
        walk_finish = (iter_r == ITER_LAST);
        iter_nxt    = iter_r + 1'b1;
        if (op.code == lps_pkg::OPC_OFF || op.code == lps_pkg::OPC_ON) begin
          case (op.lamp)
            lps_pkg::LAMP_GREEN: green_nxt = lamp_on;
            lps_pkg::LAMP_RED:   red_nxt   = lamp_on;
            default:             ;
          endcase
        end
        if (op.code == lps_pkg::OPC_LOOP) begin
          step_index_nxt = 5'd0;
        end else begin
          step_index_nxt = step_plus;
          if (op.dur != 8'd0) begin
            ticks_left_nxt  = op.dur;
            timer_armed_nxt = 1'b1;
            walk_finish     = 1'b1;
          end else if (op.code == lps_pkg::OPC_END) begin
            running_nxt = 1'b0;
            walk_finish = 1'b1;
          end else if ({1'b0, step_plus} >= STEP_LIMIT) begin
            walk_finish = 1'b1;
          end
        end
        if (walk_finish) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // load result once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_green_nxt   = green_r;
          out_red_nxt     = red_r;
          out_running_nxt = running_r;
          out_pattern_nxt = pattern_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pattern_r     <= 4'd0;
      step_index_r  <= 5'd0;
      ticks_left_r  <= 8'd0;
      timer_armed_r <= 1'b0;
      running_r     <= 1'b0;
      green_r       <= 1'b0;
      red_r         <= 1'b0;
      iter_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pattern_r     <= pattern_nxt;
      step_index_r  <= step_index_nxt;
      ticks_left_r  <= ticks_left_nxt;
      timer_armed_r <= timer_armed_nxt;
      running_r     <= running_nxt;
      green_r       <= green_nxt;
      red_r         <= red_nxt;
      iter_r        <= iter_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_green_r   <= out_green_nxt;
    out_red_r     <= out_red_nxt;
    out_running_r <= out_running_nxt;
    out_pattern_r <= out_pattern_nxt;
  end

  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_green_lit        = out_green_r;
  assign out_red_lit          = out_red_r;
  assign out_sequence_running = out_running_r;
  assign out_current_pattern  = out_pattern_r;

`ifndef NO_ASSERTIONS
  // an armed timer always has ticks remaining
  a_armed_has_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    timer_armed_r |-> (ticks_left_r != 8'd0))
    else $error("timer armed with zero ticks");

  // a finished pattern never leaves the timer armed
  a_stopped_unarmed: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> !timer_armed_r)
    else $error("timer armed after pattern end");

  // the walk only runs on a pattern held in the ROM
  a_walk_valid_pat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> pat_ok(pattern_r))
    else $error("walk on invalid pattern");
`endif

endmodule

`default_nettype wire
